// ===== sv/pdd_pkg.sv =====
`default_nettype none

package pdd_pkg;

	// Field widths
	localparam int AMP_W    = 16;
	localparam int TIME_W   = 32;
	localparam int SEQ_W    = 16;
	localparam int SUM_W    = 32;
	localparam int CNT_W    = 16;
	localparam int DIP_W    = AMP_W + 4;
	localparam int CONF_W   = 4;
	localparam int PER_W    = 16;
	localparam int CFG_IX_W = 3;
	localparam int CFG_D_W  = 16;

	// Saturation limit of the sample count
	localparam int MAX_PULSE_SAMPLES = 65535;

	// Serial divider: one quotient bit per cycle
	localparam int DIV_STEPS = SUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Detector phases
	localparam logic [1:0] PH_IDLE      = 2'd0;
	localparam logic [1:0] PH_MAYBE_ON  = 2'd1;
	localparam logic [1:0] PH_ON        = 2'd2;
	localparam logic [1:0] PH_MAYBE_OFF = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IX_W-1:0] CFG_ON_THR    = 3'd0;
	localparam logic [CFG_IX_W-1:0] CFG_OFF_THR   = 3'd1;
	localparam logic [CFG_IX_W-1:0] CFG_START_CNF = 3'd2;
	localparam logic [CFG_IX_W-1:0] CFG_END_CNF   = 3'd3;
	localparam logic [CFG_IX_W-1:0] CFG_PERIOD    = 3'd4;

	// Configuration reset values
	localparam logic [AMP_W-1:0]  RST_ON_THR    = 16'd655;
	localparam logic [AMP_W-1:0]  RST_OFF_THR   = 16'd655;
	localparam logic [CONF_W-1:0] RST_START_CNF = 4'd3;
	localparam logic [CONF_W-1:0] RST_END_CNF   = 4'd3;
	localparam logic [PER_W-1:0]  RST_PERIOD    = 16'd1;

	typedef struct packed {
		logic [AMP_W-1:0]  amplitude;
		logic [TIME_W-1:0] timestamp;
	} in_beat_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  sequence_number;
		logic [TIME_W-1:0] arrival_time;
		logic [AMP_W-1:0]  mean_amplitude;
		logic [TIME_W-1:0] pulse_width;
	} out_beat_t;

	// Controller to datapath
	typedef struct packed {
		logic step;      // apply the accepted sample to the detector
		logic div_start; // load the divider from the pulse totals
		logic div_step;  // one divider iteration
		logic load_out;  // capture the descriptor into the output register
	} pdd_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic emit;      // the presented sample confirms a pulse end
	} pdd_sts_t;

endpackage

`default_nettype wire

// ===== sv/pdd_div.sv =====
`default_nettype none

module pdd_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          step,
	input  wire logic [pdd_pkg::SUM_W-1:0]     dividend,
	input  wire logic [pdd_pkg::CNT_W-1:0]     divisor,
	output logic      [pdd_pkg::AMP_W-1:0]     mean
);

	logic [pdd_pkg::SUM_W-1:0] quo_q;
	logic [pdd_pkg::CNT_W-1:0] rem_q;
	logic [pdd_pkg::CNT_W-1:0] dvs_q;
	logic [pdd_pkg::CNT_W:0]   shifted;
	logic [pdd_pkg::CNT_W:0]   diff;
	logic                      fits;

	// Restoring step: shift in the next dividend bit, subtract when it fits
	assign shifted = {rem_q, quo_q[pdd_pkg::SUM_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q <= '0;
			rem_q <= '0;
			dvs_q <= '0;
		end else if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (step) begin
			quo_q <= {quo_q[pdd_pkg::SUM_W-2:0], fits};
			rem_q <= fits ? diff[pdd_pkg::CNT_W-1:0] : shifted[pdd_pkg::CNT_W-1:0];
		end
	end

	// Zero count gives zero; quotients past the amplitude range clamp
	always_comb begin
		if (dvs_q == '0) begin
			mean = '0;
		end else if (quo_q[pdd_pkg::SUM_W-1:pdd_pkg::AMP_W] != '0) begin
			mean = '1;
		end else begin
			mean = quo_q[pdd_pkg::AMP_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== sv/pdd_datapath.sv =====
`default_nettype none

module pdd_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire pdd_pkg::in_beat_t                 in_data,
	input  wire logic                              cfg_we,
	input  wire logic [pdd_pkg::CFG_IX_W-1:0]      cfg_index,
	input  wire logic [pdd_pkg::CFG_D_W-1:0]       cfg_data,
	input  wire pdd_pkg::pdd_cmd_t                 cmd,
	output pdd_pkg::pdd_sts_t                      sts,
	output pdd_pkg::out_beat_t                     out_data
);

	// Configuration
	logic [pdd_pkg::AMP_W-1:0]  on_thr_q;
	logic [pdd_pkg::AMP_W-1:0]  off_thr_q;
	logic [pdd_pkg::CONF_W-1:0] start_cnf_q;
	logic [pdd_pkg::CONF_W-1:0] end_cnf_q;
	logic [pdd_pkg::PER_W-1:0]  period_q;

	// Detector state
	logic [1:0]                 phase_q;
	logic [pdd_pkg::CONF_W-1:0] conf_cnt_q;
	logic [pdd_pkg::TIME_W-1:0] start_time_q;
	logic [pdd_pkg::TIME_W-1:0] end_time_q;
	logic [pdd_pkg::SUM_W-1:0]  pulse_sum_q;
	logic [pdd_pkg::CNT_W-1:0]  pulse_cnt_q;
	logic [pdd_pkg::DIP_W-1:0]  dip_sum_q;
	logic [pdd_pkg::CONF_W-1:0] dip_cnt_q;
	logic [pdd_pkg::SEQ_W-1:0]  serial_q;

	pdd_pkg::out_beat_t         out_q;

	logic                       ge_on;
	logic                       ge_off;
	logic [pdd_pkg::CONF_W-1:0] cnt_bump;
	logic                       merge_dip;
	logic [pdd_pkg::SUM_W+1:0]  sum_add;
	logic [pdd_pkg::CNT_W+1:0]  cnt_add;
	logic [pdd_pkg::SUM_W-1:0]  sum_sat;
	logic [pdd_pkg::CNT_W-1:0]  cnt_sat;
	logic [pdd_pkg::AMP_W-1:0]  mean;
	logic [pdd_pkg::TIME_W-1:0] width;

	// Threshold compares and saturating confirm counter
	assign ge_on    = in_data.amplitude >= on_thr_q;
	assign ge_off   = in_data.amplitude >= off_thr_q;
	assign cnt_bump = (conf_cnt_q == '1) ? conf_cnt_q : conf_cnt_q + 1'b1;

	// A resumed pulse folds the dip back in along with the current sample
	assign merge_dip = (phase_q == pdd_pkg::PH_MAYBE_OFF);
	assign sum_add = {2'b00, pulse_sum_q}
		+ (merge_dip ? {{(pdd_pkg::SUM_W + 2 - pdd_pkg::DIP_W){1'b0}}, dip_sum_q} : '0)
		+ {{(pdd_pkg::SUM_W + 2 - pdd_pkg::AMP_W){1'b0}}, in_data.amplitude};
	assign cnt_add = {2'b00, pulse_cnt_q}
		+ (merge_dip ? {{(pdd_pkg::CNT_W + 2 - pdd_pkg::CONF_W){1'b0}}, dip_cnt_q} : '0)
		+ (pdd_pkg::CNT_W + 2)'(1);
	assign sum_sat = (sum_add[pdd_pkg::SUM_W+1:pdd_pkg::SUM_W] != '0) ? '1
		: sum_add[pdd_pkg::SUM_W-1:0];
	assign cnt_sat = (cnt_add > (pdd_pkg::CNT_W + 2)'(pdd_pkg::MAX_PULSE_SAMPLES))
		? pdd_pkg::CNT_W'(pdd_pkg::MAX_PULSE_SAMPLES) : cnt_add[pdd_pkg::CNT_W-1:0];

	// End of pulse confirmed by this sample
	assign sts.emit = (phase_q == pdd_pkg::PH_MAYBE_OFF) && !ge_off && (cnt_bump >= end_cnf_q);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_thr_q    <= pdd_pkg::RST_ON_THR;
			off_thr_q   <= pdd_pkg::RST_OFF_THR;
			start_cnf_q <= pdd_pkg::RST_START_CNF;
			end_cnf_q   <= pdd_pkg::RST_END_CNF;
			period_q    <= pdd_pkg::RST_PERIOD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pdd_pkg::CFG_ON_THR:    on_thr_q    <= cfg_data[pdd_pkg::AMP_W-1:0];
				pdd_pkg::CFG_OFF_THR:   off_thr_q   <= cfg_data[pdd_pkg::AMP_W-1:0];
				pdd_pkg::CFG_START_CNF: start_cnf_q <= cfg_data[pdd_pkg::CONF_W-1:0];
				pdd_pkg::CFG_END_CNF:   end_cnf_q   <= cfg_data[pdd_pkg::CONF_W-1:0];
				pdd_pkg::CFG_PERIOD:    period_q    <= cfg_data[pdd_pkg::PER_W-1:0];
				default: ;
			endcase
		end
	end

	// Detector update, one sample per step command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= pdd_pkg::PH_IDLE;
			conf_cnt_q   <= '0;
			start_time_q <= '0;
			end_time_q   <= '0;
			pulse_sum_q  <= '0;
			pulse_cnt_q  <= '0;
			dip_sum_q    <= '0;
			dip_cnt_q    <= '0;
		end else if (cmd.step) begin
			unique case (phase_q)
				pdd_pkg::PH_IDLE: begin
					if (ge_on) begin
						conf_cnt_q   <= pdd_pkg::CONF_W'(1);
						phase_q      <= pdd_pkg::PH_MAYBE_ON;
						start_time_q <= in_data.timestamp;
						end_time_q   <= in_data.timestamp;
						pulse_sum_q  <= {{(pdd_pkg::SUM_W - pdd_pkg::AMP_W){1'b0}},
							in_data.amplitude};
						pulse_cnt_q  <= pdd_pkg::CNT_W'(1);
					end
				end
				pdd_pkg::PH_MAYBE_ON: begin
					if (ge_on) begin
						conf_cnt_q  <= cnt_bump;
						if (cnt_bump >= start_cnf_q) begin
							phase_q <= pdd_pkg::PH_ON;
						end
						end_time_q  <= in_data.timestamp;
						pulse_sum_q <= sum_sat;
						pulse_cnt_q <= cnt_sat;
					end else begin
						phase_q <= pdd_pkg::PH_IDLE;
					end
				end
				pdd_pkg::PH_ON: begin
					if (ge_off) begin
						end_time_q  <= in_data.timestamp;
						pulse_sum_q <= sum_sat;
						pulse_cnt_q <= cnt_sat;
					end else begin
						conf_cnt_q <= pdd_pkg::CONF_W'(1);
						phase_q    <= pdd_pkg::PH_MAYBE_OFF;
						dip_sum_q  <= {{(pdd_pkg::DIP_W - pdd_pkg::AMP_W){1'b0}},
							in_data.amplitude};
						dip_cnt_q  <= pdd_pkg::CONF_W'(1);
					end
				end
				default: begin
					if (!ge_off) begin
						conf_cnt_q <= cnt_bump;
						if (cnt_bump >= end_cnf_q) begin
							phase_q <= pdd_pkg::PH_IDLE;
						end else begin
							dip_sum_q <= dip_sum_q + {{(pdd_pkg::DIP_W - pdd_pkg::AMP_W){1'b0}},
								in_data.amplitude};
							dip_cnt_q <= dip_cnt_q + 1'b1;
						end
					end else begin
						phase_q     <= pdd_pkg::PH_ON;
						end_time_q  <= in_data.timestamp;
						pulse_sum_q <= sum_sat;
						pulse_cnt_q <= cnt_sat;
					end
				end
			endcase
		end
	end

	// Mean amplitude over the pulse
	pdd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.step     (cmd.div_step),
		.dividend (pulse_sum_q),
		.divisor  (pulse_cnt_q),
		.mean     (mean)
	);

	assign width = end_time_q - start_time_q
		+ {{(pdd_pkg::TIME_W - pdd_pkg::PER_W){1'b0}}, period_q};

	// Descriptor output register and pulse serial
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			serial_q <= '0;
		end else if (cmd.load_out) begin
			serial_q <= serial_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.sequence_number <= serial_q;
			out_q.arrival_time    <= start_time_q;
			out_q.mean_amplitude  <= mean;
			out_q.pulse_width     <= width;
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

// ===== sv/pdd_ctrl.sv =====
`default_nettype none

module pdd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire pdd_pkg::pdd_sts_t sts,
	output pdd_pkg::pdd_cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;

	logic [1:0]                   state_q;
	logic [pdd_pkg::DIV_CNT_W-1:0] step_cnt_q;
	logic                         out_valid_q;
	logic                         in_fire;
	logic                         out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Commands
	always_comb begin
		cmd.step      = in_fire;
		cmd.div_start = in_fire && sts.emit;
		cmd.div_step  = (state_q == ST_DIV);
		cmd.load_out  = (state_q == ST_LOAD) && out_free;
	end

	// Sequencer: accept, divide, hand off to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && sts.emit) begin
						state_q    <= ST_DIV;
						step_cnt_q <= '0;
					end
				end
				ST_DIV: begin
					step_cnt_q <= step_cnt_q + 1'b1;
					if (step_cnt_q == pdd_pkg::DIV_CNT_W'(pdd_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_emit_divides: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && sts.emit |=> state_q == ST_DIV && step_cnt_q == '0)
		else $error("emitting beat did not start the divider");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && step_cnt_q != pdd_pkg::DIV_CNT_W'(pdd_pkg::DIV_STEPS - 1)
		|=> state_q == ST_DIV)
		else $error("divider left before its last step");

	a_load_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !out_valid_q || out_ready)
		else $error("descriptor overwrote an untaken beat");

	a_load_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD && out_valid_q && !out_ready |=> state_q == ST_LOAD)
		else $error("descriptor dropped while output stalled");

endmodule

`default_nettype wire

// ===== sv/pulse_descriptor_detector_core.sv =====
// A sample that does not end a pulse is absorbed in the cycle it is accepted. A sample
// that confirms a pulse end loads the serial mean divider; after its 32 iterations the
// descriptor is loaded into the output register, waiting while an untaken beat is held.
// Input takes one sample per cycle, but is held off until a pulse end has been loaded.
// Reset (arst_n low) clears the detector to idle, the serial to zero, the output valid,
// and loads the configuration defaults; no clearing pass is needed.
`default_nettype none

module pulse_descriptor_detector_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire pdd_pkg::in_beat_t            in_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output pdd_pkg::out_beat_t                out_data,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [pdd_pkg::CFG_IX_W-1:0] cfg_index,
	input  wire logic [pdd_pkg::CFG_D_W-1:0]  cfg_data
);

	pdd_pkg::pdd_cmd_t cmd;
	pdd_pkg::pdd_sts_t sts;
	logic              cfg_we;

	// Configuration beats always taken
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	pdd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pdd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
